>>> rtl/wrapping_sequence_sorted_queue_macros.svh
// Assertion macros used by the checker file of the sorted packet queue.
// No dependencies; include by bare file name.
`ifndef WRAPPING_SEQUENCE_SORTED_QUEUE_MACROS_SVH
`define WRAPPING_SEQUENCE_SORTED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSSQ_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSSQ_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wssq_pkg.sv
// Package for the wrapping sequence sorted queue: field widths, codes,
// controller/datapath command and status structs, and the recency function.
`default_nettype none

package wssq_pkg;

  localparam int SEQ_W      = 32;
  localparam int PAY_W      = 16;
  localparam int POS_W      = 6;
  localparam int OCC_W      = 7;
  localparam int STAT_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_PLACED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // register index is paddr[2]
  localparam logic REG_MAX_SEQ = 1'b0;
  localparam logic [SEQ_W-1:0] MAX_SEQ_RESET = '1;

  typedef enum logic [1:0] {
    RA_IDX  = 2'd0,
    RA_ZERO = 2'd1,
    RA_TAIL = 2'd2,
    RA_PREV = 2'd3
  } rd_addr_t;

  typedef struct packed {
    logic              latch;
    logic              rd_en;
    rd_addr_t          rd_addr;
    logic              idx_clr;
    logic              idx_inc;
    logic              idx_dec;
    logic              idx_load_cnt;
    logic              pos_idx;
    logic              pos_cnt;
    logic              wr_shift;
    logic              wr_new;
    logic              cnt_inc;
    logic              found_set;
    logic              set_stat;
    logic [STAT_W-1:0] stat;
    logic              res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic cnt_zero;
    logic cnt_full;
    logic seq_newer;   // request newer than the entry just read
    logic ent_newer;   // entry just read newer than the request
    logic hit;
    logic idx_last;
    logic shift_more;
    logic res_free;
  } dp_stat_t;

  // a is more recent than b, modulo the horizon h
  function automatic logic newer(input logic [SEQ_W-1:0] a,
                                 input logic [SEQ_W-1:0] b,
                                 input logic [SEQ_W-1:0] h);
    logic res;
    if (a > b) begin
      res = ((a - b) <= h);
    end else if (b > a) begin
      res = ((b - a) > h);
    end else begin
      res = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/wssq_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on wssq_pkg for field widths.
`default_nettype none

interface wssq_in_if;
  import wssq_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [SEQ_W-1:0]   sequence_req;
  logic [PAY_W-1:0]   payload;
  modport source (output valid, op, sequence_req, payload, input ready);
  modport sink   (input valid, op, sequence_req, payload, output ready);
endinterface

interface wssq_out_if;
  import wssq_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [STAT_W-1:0]  status;
  logic [POS_W-1:0]   position;
  logic [OCC_W-1:0]   occupancy;
  modport source (output valid, found, status, position, occupancy, input ready);
  modport sink   (input valid, found, status, position, occupancy, output ready);
endinterface

`default_nettype wire

>>> rtl/wssq_regs.sv
// APB configuration register block: holds the sequence limit register.
// Depends on wssq_pkg.
`default_nettype none

module wssq_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wssq_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wssq_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wssq_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [wssq_pkg::SEQ_W-1:0]       max_seq
);
  import wssq_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_SEQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seq <= MAX_SEQ_RESET;
    end else if (wr_hit) begin
      max_seq <= pwdata[SEQ_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_SEQ) ? max_seq : '0;

endmodule

`default_nettype wire

>>> rtl/wssq_ctrl.sv
// Sequencer for the sorted queue: accepts a request, steps the datapath
// through head/tail checks, scan, shift and write. Depends on wssq_pkg.
`default_nettype none

module wssq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output wssq_pkg::dp_cmd_t  cmd,
  input  wssq_pkg::dp_stat_t st
);
  import wssq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECIDE   = 12'b0000_0000_0010,
    S_HEAD_CMP = 12'b0000_0000_0100,
    S_TAIL_CMP = 12'b0000_0000_1000,
    S_SCAN_RD  = 12'b0000_0001_0000,
    S_SCAN_CMP = 12'b0000_0010_0000,
    S_LOOK_RD  = 12'b0000_0100_0000,
    S_LOOK_CMP = 12'b0000_1000_0000,
    S_SH_CHK   = 12'b0001_0000_0000,
    S_SH_WR    = 12'b0010_0000_0000,
    S_WR_NEW   = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.op == OP_LOOKUP) begin
          if (st.cnt_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = S_LOOK_RD;
          end
        end else if (st.cnt_full) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = STAT_FULL;
          state_next   = S_DONE;
        end else if (st.cnt_zero) begin
          state_next = S_WR_NEW;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_ZERO;
          state_next  = S_HEAD_CMP;
        end
      end
      S_HEAD_CMP: begin
        // not newer than the head: goes to the front
        if (!st.seq_newer) begin
          cmd.idx_load_cnt = 1'b1;
          state_next       = S_SH_CHK;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_TAIL;
          state_next  = S_TAIL_CMP;
        end
      end
      S_TAIL_CMP: begin
        if (st.seq_newer) begin
          cmd.pos_cnt = 1'b1;
          state_next  = S_WR_NEW;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = RA_IDX;
        state_next  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (st.ent_newer) begin
          cmd.pos_idx      = 1'b1;
          cmd.idx_load_cnt = 1'b1;
          state_next       = S_SH_CHK;
        end else if (st.idx_last) begin
          // no slot found, typically equal to the tail
          cmd.set_stat = 1'b1;
          cmd.stat     = STAT_DROPPED;
          state_next   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_LOOK_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = RA_IDX;
        state_next  = S_LOOK_CMP;
      end
      S_LOOK_CMP: begin
        if (st.hit) begin
          cmd.found_set = 1'b1;
          state_next    = S_DONE;
        end else if (st.idx_last) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_LOOK_RD;
        end
      end
      S_SH_CHK: begin
        // move entries up from the tail down to the insert slot
        if (st.shift_more) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = RA_PREV;
          state_next  = S_SH_WR;
        end else begin
          state_next = S_WR_NEW;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_next   = S_SH_CHK;
      end
      S_WR_NEW: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (st.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/wssq_dpath.sv
// Datapath of the sorted queue: entry memory, count, index and slot
// registers, recency compare, result register. Depends on wssq_pkg.
`default_nettype none

module wssq_dpath #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wssq_pkg::dp_cmd_t             cmd,
  output wssq_pkg::dp_stat_t            st,
  input  logic [wssq_pkg::SEQ_W-1:0]    max_seq,
  input  logic                          in_op,
  input  logic [wssq_pkg::SEQ_W-1:0]    in_seq,
  input  logic [wssq_pkg::PAY_W-1:0]    in_pay,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_found,
  output logic [wssq_pkg::STAT_W-1:0]   res_status,
  output logic [wssq_pkg::POS_W-1:0]    res_position,
  output logic [wssq_pkg::OCC_W-1:0]    res_occupancy
);
  import wssq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = SEQ_W + PAY_W;

  // entry: payload above, sequence in the low bits
  logic [EW-1:0]     mem [DEPTH];
  logic [EW-1:0]     rdata;
  logic [EW-1:0]     wdata;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              we;

  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     idx_m1;
  logic [AW-1:0]     pos;
  logic              op_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [PAY_W-1:0]  pay_q;
  logic [STAT_W-1:0] stat_q;
  logic              found_q;
  logic [SEQ_W-1:0]  rseq;
  logic [SEQ_W-1:0]  half;

  assign cnt_m1 = count - CW'(1);
  assign idx_m1 = idx - CW'(1);
  assign rseq   = rdata[SEQ_W-1:0];
  assign half   = max_seq >> 1;

  always_comb begin
    case (cmd.rd_addr)
      RA_IDX:  raddr = idx[AW-1:0];
      RA_ZERO: raddr = '0;
      RA_TAIL: raddr = cnt_m1[AW-1:0];
      RA_PREV: raddr = idx_m1[AW-1:0];
      default: raddr = '0;
    endcase
  end

  assign we    = cmd.wr_shift || cmd.wr_new;
  assign waddr = cmd.wr_new ? pos : idx[AW-1:0];
  assign wdata = cmd.wr_new ? {pay_q, seq_q} : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end else if (cmd.idx_load_cnt) begin
      idx <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pos <= '0;
    end else if (cmd.pos_idx) begin
      pos <= idx[AW-1:0];
    end else if (cmd.pos_cnt) begin
      pos <= count[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= in_op;
      seq_q   <= in_seq;
      pay_q   <= in_pay;
      found_q <= 1'b0;
      stat_q  <= STAT_PLACED;
    end else begin
      if (cmd.found_set) begin
        found_q <= 1'b1;
      end
      if (cmd.set_stat) begin
        stat_q <= cmd.stat;
      end
    end
  end

  // result register, holds until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_found     <= found_q;
      res_status    <= stat_q;
      res_position  <= POS_W'(pos);
      res_occupancy <= OCC_W'(count);
    end
  end

  always_comb begin
    st.op         = op_q;
    st.cnt_zero   = (count == '0);
    st.cnt_full   = (count == CW'(DEPTH));
    st.seq_newer  = newer(seq_q, rseq, half);
    st.ent_newer  = newer(rseq, seq_q, half);
    st.hit        = (rseq == seq_q);
    st.idx_last   = ((idx + CW'(1)) == count);
    st.shift_more = (idx > CW'(pos));
    st.res_free   = !res_valid || res_ready;
  end

endmodule

`default_nettype wire

>>> rtl/wrapping_sequence_sorted_queue.sv
// Top level of the wrapping sequence sorted queue: request/result channels,
// APB config port. Depends on wssq_pkg, wssq_if, wssq_regs, wssq_ctrl, wssq_dpath.
`default_nettype none

// Sorted packet queue holding up to DEPTH entries (sequence + payload) in a
// single-port-write memory, ordered oldest first with wrapping recency
// (horizon is half the sequence limit register). One request is handled at a
// time; the memory gives one registered read per cycle, so the work is a walk
// over entries. A lookup reads entries from the head until a hit or the last
// entry. An insert reads the head, then the tail; one between them scans for
// the first newer entry, and a scan that finds none drops the request. Entries
// from the tail down to the slot move up one at a time before the new entry is
// written. A full-queue reject and an insert into an empty queue read nothing.
// The next request is taken in the idle state that follows the result load.
// The result sits in an output register, so the next request can enter while
// the previous result waits; a second result then holds the sequencer in its
// last state until the register frees. The sequence limit is written over APB
// at byte address 0 and must only change while the queue is idle.
module wrapping_sequence_sorted_queue #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  wssq_in_if.sink                          cmd,
  wssq_out_if.source                       res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wssq_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wssq_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wssq_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import wssq_pkg::*;

  logic [SEQ_W-1:0] max_seq;
  dp_cmd_t          dp_cmd;
  dp_stat_t         dp_st;

  wssq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_seq (max_seq)
  );

  wssq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .cmd      (dp_cmd),
    .st       (dp_st)
  );

  wssq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .st            (dp_st),
    .max_seq       (max_seq),
    .in_op         (cmd.op),
    .in_seq        (cmd.sequence_req),
    .in_pay        (cmd.payload),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_found     (res.found),
    .res_status    (res.status),
    .res_position  (res.position),
    .res_occupancy (res.occupancy)
  );

endmodule

`default_nettype wire

>>> rtl/wssq_chk.sv
// Port-level checker for the sorted queue, bound to the top level.
// Depends on wssq_pkg and the assertion macro header.
`default_nettype none
`include "wrapping_sequence_sorted_queue_macros.svh"

module wssq_chk #(
  parameter int DEPTH = 64
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          found,
  input logic [wssq_pkg::STAT_W-1:0]   status,
  input logic [wssq_pkg::POS_W-1:0]    position,
  input logic [wssq_pkg::OCC_W-1:0]    occupancy
);
  import wssq_pkg::*;

  // a stalled result beat holds its contents
  `WSSQ_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(found) && $stable(status) && $stable(position) && $stable(occupancy), "result beat changed while stalled")

  // one request in flight: busy right after an accept
  `WSSQ_ASSERT_NXT(a_busy_after_accept, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "request accepted while previous still in work")

  // no stale result right after reset
  `WSSQ_ASSERT_IMP(a_reset_clears, clk, rst, $past(rst), !res_valid, "result valid right after reset")

  // a rejected insert sees a full queue
  `WSSQ_ASSERT_IMP(a_full_occ, clk, rst, res_valid && (status == STAT_FULL), occupancy == OCC_W'(DEPTH), "full status with queue not full")

endmodule

bind wrapping_sequence_sorted_queue wssq_chk #(
  .DEPTH (DEPTH)
) u_wssq_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .found     (res.found),
  .status    (res.status),
  .position  (res.position),
  .occupancy (res.occupancy)
);

`default_nettype wire
